// ----- src/csv_text_sample_builder_core_macros.svh -----
// Assertion macros shared by the sample builder modules.
`ifndef CSV_TEXT_SAMPLE_BUILDER_CORE_MACROS_SVH
`define CSV_TEXT_SAMPLE_BUILDER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CSVSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("csvsb assertion failed");

// next-cycle implication
`define CSVSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("csvsb assertion failed");

`else

`define CSVSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CSVSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/csvsb_pkg.sv -----
package csvsb_pkg;

	// field widths
	localparam int MODE_W    = 2;
	localparam int CP_W      = 21;
	localparam int IDX_W     = 10;
	localparam int LIM_W     = 10;
	localparam int BYTE_W    = 8;
	localparam int OUT_LEN_W = 10;

	// beat layouts
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 24;

	localparam logic [LIM_W-1:0] LIMIT_RESET = 10'd512;
	localparam int               LIMIT_MIN   = 4;

	// characters
	localparam logic [CP_W-1:0]   CH_QUOTE   = 21'h22;
	localparam logic [CP_W-1:0]   CH_COMMA   = 21'h2C;
	localparam logic [CP_W-1:0]   CH_SPACE   = 21'h20;
	localparam logic [CP_W-1:0]   CH_NBSP    = 21'hA0;
	localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] BYTE_DOT   = 8'h2E;

	typedef enum logic [MODE_W-1:0] {
		MODE_START = 2'd0,
		MODE_PUSH  = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	// write list handed from control to the store
	typedef struct packed {
		logic                   load;
		logic [2:0]             app_cnt;
		logic [3:0][BYTE_W-1:0] app_bytes;
		logic                   cut;
		logic                   cut_space;
	} wr_cmd_t;

	// writer status
	typedef struct packed {
		logic idle;
		logic free_next;
	} wr_stat_t;

endpackage

// ----- src/csvsb_ctrl.sv -----
`include "csv_text_sample_builder_core_macros.svh"

module csvsb_ctrl
	import csvsb_pkg::*;
#(
	parameter int MAX_SAMPLE = 512,
	parameter int AW         = $clog2(MAX_SAMPLE + 4),
	parameter int LEN_W      = (AW > IDX_W) ? AW : IDX_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  mode_t            mode,
	input  logic [CP_W-1:0]  code_point,
	input  logic [LIM_W-1:0] sample_limit,
	output logic [LEN_W-1:0] length,
	output logic             closed,
	output wr_cmd_t          cmd,
	output logic [AW-1:0]    app_pos,
	output logic [AW-1:0]    cut_pos
);

	logic [LEN_W-1:0] len_q, word_end_q;
	logic             in_quotes_q, after_space_q, quote_pend_q, closed_q;

	logic [LEN_W-1:0] n_len, n_we;
	logic             n_inq, n_as, n_qp, n_closed;

	logic [LEN_W-1:0] lim, lim_ext, len_sum, cut_tmp;
	logic [CP_W-1:0]  ch;
	logic             go, app;
	logic [2:0]       cnt;
	logic [3:0][BYTE_W-1:0] bytes;

	// clamp the limit into [4, MAX_SAMPLE]
	always_comb begin
		lim_ext = LEN_W'(sample_limit);
		if (lim_ext < LEN_W'(LIMIT_MIN)) begin
			lim = LEN_W'(LIMIT_MIN);
		end else if (lim_ext > LEN_W'(MAX_SAMPLE)) begin
			lim = LEN_W'(MAX_SAMPLE);
		end else begin
			lim = lim_ext;
		end
	end

	// next state and write list for one item
	always_comb begin
		n_len    = len_q;
		n_we     = word_end_q;
		n_inq    = in_quotes_q;
		n_as     = after_space_q;
		n_qp     = quote_pend_q;
		n_closed = closed_q;
		ch       = code_point;
		go       = 1'b0;
		app      = 1'b0;
		cnt      = '0;
		bytes    = '0;
		len_sum  = len_q;
		cut_tmp  = '0;
		cmd      = '0;
		unique case (mode)
			MODE_START: begin
				n_len    = '0;
				n_we     = '0;
				n_inq    = 1'b0;
				n_as     = 1'b1;
				n_qp     = 1'b0;
				n_closed = 1'b0;
			end
			MODE_PUSH: begin
				if (!closed_q) begin
					go = 1'b1;
					// quote handling
					if (quote_pend_q) begin
						n_qp = 1'b0;
						if (code_point != CH_QUOTE) begin
							n_inq = 1'b0;
							if (code_point == CH_COMMA) ch = CH_SPACE;
						end
					end else if (!in_quotes_q) begin
						if (code_point == CH_QUOTE) begin
							n_inq = 1'b1;
							go    = 1'b0;
						end else if (code_point == CH_COMMA) begin
							ch = CH_SPACE;
						end
					end else if (code_point == CH_QUOTE) begin
						n_qp = 1'b1;
						go   = 1'b0;
					end

					if (go) begin
						if (ch <= CH_SPACE || ch == CH_NBSP) begin
							// whitespace run collapses to one space
							if (!after_space_q) begin
								n_we     = len_q;
								bytes[0] = BYTE_SPACE;
								cnt      = 3'd1;
								n_as     = 1'b1;
								app      = 1'b1;
							end
						end else begin
							// UTF-8 encode
							app  = 1'b1;
							n_as = 1'b0;
							if (ch < 21'h80) begin
								bytes[0] = {1'b0, ch[6:0]};
								cnt      = 3'd1;
							end else if (ch < 21'h800) begin
								bytes[0] = {3'b110, ch[10:6]};
								bytes[1] = {2'b10, ch[5:0]};
								cnt      = 3'd2;
							end else if (ch < 21'h10000) begin
								bytes[0] = {4'b1110, ch[15:12]};
								bytes[1] = {2'b10, ch[11:6]};
								bytes[2] = {2'b10, ch[5:0]};
								cnt      = 3'd3;
							end else begin
								bytes[0] = {5'b11110, ch[20:18]};
								bytes[1] = {2'b10, ch[17:12]};
								bytes[2] = {2'b10, ch[11:6]};
								bytes[3] = {2'b10, ch[5:0]};
								cnt      = 3'd4;
							end
						end

						if (app) begin
							len_sum       = len_q + LEN_W'(cnt);
							n_len         = len_sum;
							cmd.load      = step;
							cmd.app_cnt   = cnt;
							cmd.app_bytes = bytes;
							// limit reached: cut and close
							if (len_sum >= lim) begin
								n_closed = 1'b1;
								cmd.cut  = 1'b1;
								if (n_we <= (lim >> 1) || n_we >= lim) begin
									cut_tmp       = lim - LEN_W'(3);
									n_len         = lim;
									cmd.cut_space = 1'b0;
								end else begin
									cut_tmp       = n_we;
									n_len         = n_we + LEN_W'(4);
									cmd.cut_space = 1'b1;
								end
							end
						end
					end
				end
			end
			MODE_READ: begin
			end
			MODE_NOP: begin
			end
		endcase
	end

	assign app_pos = len_q[AW-1:0];
	assign cut_pos = cut_tmp[AW-1:0];
	assign length  = len_q;
	assign closed  = closed_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q         <= '0;
			word_end_q    <= '0;
			in_quotes_q   <= 1'b0;
			after_space_q <= 1'b1;
			quote_pend_q  <= 1'b0;
			closed_q      <= 1'b0;
		end else if (step) begin
			len_q         <= n_len;
			word_end_q    <= n_we;
			in_quotes_q   <= n_inq;
			after_space_q <= n_as;
			quote_pend_q  <= n_qp;
			closed_q      <= n_closed;
		end
	end

	// a closed sample ignores pushes
	`CSVSB_ASSERT_NEXT(a_closed_hold, clk, arst_n, closed_q && step && mode == MODE_PUSH, $stable(len_q) && closed_q)
	// an open sample stays below the cap
	`CSVSB_ASSERT_NOW(a_open_len, clk, arst_n, !closed_q, len_q < LEN_W'(MAX_SAMPLE))

endmodule

// ----- src/csvsb_store.sv -----
`include "csv_text_sample_builder_core_macros.svh"

module csvsb_store
	import csvsb_pkg::*;
#(
	parameter int MAX_SAMPLE = 512,
	parameter int DEPTH      = MAX_SAMPLE + 4,
	parameter int AW         = $clog2(MAX_SAMPLE + 4)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wr_cmd_t           cmd,
	input  logic [AW-1:0]     app_pos,
	input  logic [AW-1:0]     cut_pos,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data,
	output wr_stat_t          stat
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	// two write segments: appended bytes, then the cut marker
	logic [AW-1:0]          a_pos_q, b_pos_q;
	logic [3:0][BYTE_W-1:0] a_bytes_q, b_bytes_q;
	logic [2:0]             a_cnt_q, b_cnt_q;

	logic              a_act, b_act, we;
	logic [AW-1:0]     waddr;
	logic [BYTE_W-1:0] wdata;
	logic [3:0]        rem;

	assign a_act = (a_cnt_q != 3'd0);
	assign b_act = !a_act && (b_cnt_q != 3'd0);
	assign we    = a_act || b_act;
	assign waddr = a_act ? a_pos_q : b_pos_q;
	assign wdata = a_act ? a_bytes_q[0] : b_bytes_q[0];
	assign rem   = {1'b0, a_cnt_q} + {1'b0, b_cnt_q};

	assign stat.idle      = (rem == 4'd0);
	assign stat.free_next = (rem <= 4'd1);

	// write sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cnt_q <= '0;
			b_cnt_q <= '0;
		end else if (cmd.load) begin
			a_cnt_q <= cmd.app_cnt;
			b_cnt_q <= cmd.cut ? (cmd.cut_space ? 3'd4 : 3'd3) : 3'd0;
		end else if (a_act) begin
			a_cnt_q <= a_cnt_q - 3'd1;
		end else if (b_act) begin
			b_cnt_q <= b_cnt_q - 3'd1;
		end
	end

	// segment payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_pos_q   <= app_pos;
			a_bytes_q <= cmd.app_bytes;
			b_pos_q   <= cut_pos;
			b_bytes_q <= cmd.cut_space ? {BYTE_DOT, BYTE_DOT, BYTE_DOT, BYTE_SPACE}
			                           : {8'h00, BYTE_DOT, BYTE_DOT, BYTE_DOT};
		end else if (a_act) begin
			a_pos_q   <= a_pos_q + AW'(1);
			a_bytes_q <= a_bytes_q >> BYTE_W;
		end else if (b_act) begin
			b_pos_q   <= b_pos_q + AW'(1);
			b_bytes_q <= b_bytes_q >> BYTE_W;
		end
	end

	// sample memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

	// a new write list only lands when at most the old one's last byte is left to write
	`CSVSB_ASSERT_NOW(a_load_free, clk, arst_n, cmd.load, stat.free_next)
	// reads never race a pending write
	`CSVSB_ASSERT_NOW(a_read_idle, clk, arst_n, rd_en, stat.idle)

endmodule

// ----- src/csv_text_sample_builder_core.sv -----
// Channel   Dir  Beat fields (low bit up)
// s_axis    in   tuser: mode; tdata: code_point, read_index
// m_axis    out  tdata: data_byte, sample_length, truncated
// cfg       in   cfg_data: sample_limit
//
// Every item's result passes through stage 1 and then into an output register.
// A push ties up the byte-wide write port for each of its UTF-8 bytes (1 to 4), plus
// the 3 or 4 bytes of the cut marker. The next push waits until one byte at most is left.
// A read waits for all pending writes; start and no-op items pass every cycle unless
// m_axis stalls. Reset clears control state only; the sample memory needs no clearing pass.
// A stalled m_axis holds one result in the output register and one in flight.
`include "csv_text_sample_builder_core_macros.svh"

module csv_text_sample_builder_core
	import csvsb_pkg::*;
#(
	parameter int MAX_SAMPLE = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // code_point, read_index, pad
	input  logic [MODE_W-1:0]     s_axis_tuser,  // mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // data_byte, sample_length, truncated, pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [LIM_W-1:0]      cfg_data
);

	localparam int AW    = $clog2(MAX_SAMPLE + 4);
	localparam int LEN_W = (AW > IDX_W) ? AW : IDX_W;

	mode_t             in_mode;
	logic [CP_W-1:0]   in_cp;
	logic [IDX_W-1:0]  in_idx;
	logic [LEN_W-1:0]  idx_ext, length;
	logic              closed, accept, adv, haz_ok, rd_hit;
	logic [LIM_W-1:0]  limit_q;
	wr_cmd_t           cmd;
	wr_stat_t          stat;
	logic [AW-1:0]     app_pos, cut_pos;
	logic [BYTE_W-1:0] rd_data;

	logic              valid_s1, rd_hit_s1;
	logic              out_valid_q, out_trunc_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [OUT_LEN_W-1:0] out_len_q;

	// beat unpacking
	assign in_mode = mode_t'(s_axis_tuser);
	assign in_cp   = s_axis_tdata[CP_W-1:0];
	assign in_idx  = s_axis_tdata[CP_W+IDX_W-1:CP_W];
	assign idx_ext = LEN_W'(in_idx);

	// hazard check against the write sequencer
	always_comb begin
		priority if (in_mode == MODE_READ) begin
			haz_ok = stat.idle;
		end else if (in_mode == MODE_PUSH) begin
			haz_ok = stat.free_next;
		end else begin
			haz_ok = 1'b1;
		end
	end

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = (!valid_s1 || adv) && haz_ok;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign rd_hit        = accept && (in_mode == MODE_READ) && (idx_ext < length);

	// limit register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	csvsb_ctrl #(
		.MAX_SAMPLE (MAX_SAMPLE)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (accept),
		.mode         (in_mode),
		.code_point   (in_cp),
		.sample_limit (limit_q),
		.length       (length),
		.closed       (closed),
		.cmd          (cmd),
		.app_pos      (app_pos),
		.cut_pos      (cut_pos)
	);

	csvsb_store #(
		.MAX_SAMPLE (MAX_SAMPLE)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.app_pos (app_pos),
		.cut_pos (cut_pos),
		.rd_en   (rd_hit),
		.rd_addr (idx_ext[AW-1:0]),
		.rd_data (rd_data),
		.stat    (stat)
	);

	// stage 1: memory read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_hit_s1 <= rd_hit;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q  <= rd_hit_s1 ? rd_data : '0;
			out_len_q   <= length[OUT_LEN_W-1:0];
			out_trunc_q <= closed;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - BYTE_W - OUT_LEN_W - 1){1'b0}},
	                        out_trunc_q, out_len_q, out_byte_q};

	// a result enters stage 1 in the cycle after its beat is accepted
	`CSVSB_ASSERT_NEXT(a_s1_fill, clk, arst_n, accept, valid_s1)
	// stage 1 never drops a result that has not moved on
	`CSVSB_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv, valid_s1 && $stable(rd_hit_s1))

endmodule

// ----- tb/csv_text_sample_builder_core_test.sv -----
`timescale 1ns / 100ps

module csv_text_sample_builder_core_test;
	import csvsb_pkg::*;

	localparam int SAMPLE_CAP     = 512;
	localparam int STORE_DEPTH    = SAMPLE_CAP + 4;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF       = 300;

	typedef struct packed {
		logic [BYTE_W-1:0]    data_byte;
		logic [OUT_LEN_W-1:0] sample_length;
		logic                 truncated;
	} sample_result_t;

	typedef enum bit {ROW_ITEM, ROW_LIMIT} row_kind_t;

	// directed row; a limit row carries the register value in its idx column
	typedef struct {
		row_kind_t         kind;
		mode_t             mode;
		logic [CP_W-1:0]   cp;
		logic [IDX_W-1:0]  idx;
		bit                typed;
		logic [BYTE_W-1:0] data_v;
		logic [9:0]        len_v;
		bit                trunc_v;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [MODE_W-1:0]     s_axis_tuser = MODE_NOP;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [LIM_W-1:0]      cfg_data = '0;

	// mirror of the sample state
	logic [BYTE_W-1:0] mirror_store [0:STORE_DEPTH-1];
	int unsigned       mirror_len = 0;
	int unsigned       mirror_word_end = 0;
	bit                mirror_quoted = 1'b0;
	bit                mirror_after_space = 1'b1;
	bit                mirror_quote_pending = 1'b0;
	bit                mirror_closed = 1'b0;
	logic [LIM_W-1:0]  limit_reg = LIMIT_RESET;

	sample_result_t results_due [$];
	int             mismatches = 0;
	int             results_seen = 0;
	bit             sender_tight = 1'b0;
	int             idle_cycles = 0;

	script_row_t script_rows [0:26] = '{
		'{ROW_ITEM,  MODE_READ, 21'h0,      10'd0,   1, 8'h00, 10'd0,  0}, // empty sample
		'{ROW_ITEM,  MODE_NOP,  21'h1FFFFF, 10'h3FF, 1, 8'h00, 10'd0,  0},
		'{ROW_ITEM,  MODE_PUSH, CH_QUOTE,   10'd0,   1, 8'h00, 10'd0,  0}, // opening quote dropped
		'{ROW_ITEM,  MODE_PUSH, CH_QUOTE,   10'd0,   0, 8'h00, 10'd0,  0},
		'{ROW_ITEM,  MODE_PUSH, CH_QUOTE,   10'd0,   0, 8'h00, 10'd0,  0}, // doubled: literal
		'{ROW_ITEM,  MODE_PUSH, CH_COMMA,   10'd0,   0, 8'h00, 10'd0,  0}, // comma kept in quotes
		'{ROW_ITEM,  MODE_PUSH, CH_QUOTE,   10'd0,   0, 8'h00, 10'd0,  0},
		'{ROW_ITEM,  MODE_PUSH, CH_COMMA,   10'd0,   0, 8'h00, 10'd0,  0}, // closes, then space
		'{ROW_ITEM,  MODE_PUSH, 21'h0,      10'd0,   0, 8'h00, 10'd0,  0}, // collapsed
		'{ROW_ITEM,  MODE_PUSH, CH_NBSP,    10'd0,   0, 8'h00, 10'd0,  0}, // collapsed
		'{ROW_ITEM,  MODE_PUSH, 21'h7FF,    10'd0,   0, 8'h00, 10'd0,  0},
		'{ROW_ITEM,  MODE_PUSH, 21'hFFFF,   10'd0,   0, 8'h00, 10'd0,  0},
		'{ROW_ITEM,  MODE_PUSH, 21'h1FFFFF, 10'd0,   0, 8'h00, 10'd0,  0}, // beyond Unicode
		'{ROW_ITEM,  MODE_PUSH, 21'h10FFFF, 10'd0,   0, 8'h00, 10'd0,  0},
		'{ROW_ITEM,  MODE_READ, 21'h0,      10'h3FF, 1, 8'h00, 10'd16, 0}, // past length
		'{ROW_ITEM,  MODE_PUSH, CH_SPACE,   10'd0,   0, 8'h00, 10'd0,  0},
		'{ROW_LIMIT, MODE_NOP,  21'h0,      10'd10,  0, 8'h00, 10'd0,  0}, // lowered mid-sample
		'{ROW_ITEM,  MODE_PUSH, 21'h62,     10'd0,   0, 8'h00, 10'd0,  0}, // cut as "..."
		'{ROW_ITEM,  MODE_PUSH, 21'h63,     10'd0,   1, 8'h00, 10'd10, 1}, // ignored when closed
		'{ROW_ITEM,  MODE_READ, 21'h0,      10'd9,   1, BYTE_DOT, 10'd10, 1},
		'{ROW_LIMIT, MODE_NOP,  21'h0,      10'd0,   0, 8'h00, 10'd0,  0}, // acts as 4
		'{ROW_ITEM,  MODE_START, 21'h0,     10'd0,   1, 8'h00, 10'd0,  0},
		'{ROW_ITEM,  MODE_PUSH, 21'h61,     10'd0,   0, 8'h00, 10'd0,  0},
		'{ROW_ITEM,  MODE_PUSH, CH_SPACE,   10'd0,   0, 8'h00, 10'd0,  0},
		'{ROW_ITEM,  MODE_PUSH, 21'h62,     10'd0,   0, 8'h00, 10'd0,  0},
		'{ROW_ITEM,  MODE_PUSH, 21'h63,     10'd0,   0, 8'h00, 10'd0,  0},
		'{ROW_ITEM,  MODE_READ, 21'h0,      10'd0,   0, 8'h00, 10'd0,  0}
	};

	csv_text_sample_builder_core #(
		.MAX_SAMPLE(SAMPLE_CAP)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void append_sample_byte(logic [BYTE_W-1:0] b);
		if (mirror_len < STORE_DEPTH) mirror_store[mirror_len] = b;
		mirror_len++;
	endfunction

	// advance the mirrored sample by one item and return its result beat
	function automatic sample_result_t sample_step(mode_t m, logic [CP_W-1:0] cp,
			logic [IDX_W-1:0] idx);
		logic [CP_W-1:0] ch;
		bit              skip;
		int unsigned     lim;
		sample_result_t  res;

		res = '0;
		if (m == MODE_START) begin
			mirror_len = 0;
			mirror_word_end = 0;
			mirror_quoted = 1'b0;
			mirror_after_space = 1'b1;
			mirror_quote_pending = 1'b0;
			mirror_closed = 1'b0;
		end else if (m == MODE_PUSH && !mirror_closed) begin
			ch = cp;
			skip = 1'b0;
			// quote handling
			if (mirror_quote_pending) begin
				mirror_quote_pending = 1'b0;
				if (ch != CH_QUOTE) begin
					mirror_quoted = 1'b0;
					if (ch == CH_COMMA) ch = CH_SPACE;
				end
			end else if (!mirror_quoted) begin
				if (ch == CH_QUOTE) begin
					mirror_quoted = 1'b1;
					skip = 1'b1;
				end else if (ch == CH_COMMA) begin
					ch = CH_SPACE;
				end
			end else if (ch == CH_QUOTE) begin
				mirror_quote_pending = 1'b1;
				skip = 1'b1;
			end
			// whitespace collapse or UTF-8 append
			if (!skip) begin
				if (ch <= CH_SPACE || ch == CH_NBSP) begin
					if (mirror_after_space) begin
						skip = 1'b1;
					end else begin
						mirror_word_end = mirror_len;
						append_sample_byte(BYTE_SPACE);
						mirror_after_space = 1'b1;
					end
				end else begin
					if (ch < 21'h80) begin
						append_sample_byte(ch[7:0]);
					end else if (ch < 21'h800) begin
						append_sample_byte(8'hC0 | 8'(ch >> 6));
						append_sample_byte(8'h80 | 8'(ch & 21'h3F));
					end else if (ch < 21'h10000) begin
						append_sample_byte(8'hE0 | 8'(ch >> 12));
						append_sample_byte(8'h80 | 8'((ch >> 6) & 21'h3F));
						append_sample_byte(8'h80 | 8'(ch & 21'h3F));
					end else begin
						append_sample_byte(8'hF0 | 8'((ch >> 18) & 21'h7));
						append_sample_byte(8'h80 | 8'((ch >> 12) & 21'h3F));
						append_sample_byte(8'h80 | 8'((ch >> 6) & 21'h3F));
						append_sample_byte(8'h80 | 8'(ch & 21'h3F));
					end
					mirror_after_space = 1'b0;
				end
			end
			// cut and close at the limit
			if (!skip) begin
				if (limit_reg < LIMIT_MIN) lim = LIMIT_MIN;
				else if (limit_reg > SAMPLE_CAP) lim = SAMPLE_CAP;
				else lim = limit_reg;
				if (mirror_len >= lim) begin
					if (mirror_word_end <= lim / 2 || mirror_word_end >= lim) begin
						mirror_store[lim-3] = BYTE_DOT;
						mirror_store[lim-2] = BYTE_DOT;
						mirror_store[lim-1] = BYTE_DOT;
						mirror_len = lim;
					end else begin
						mirror_store[mirror_word_end]   = BYTE_SPACE;
						mirror_store[mirror_word_end+1] = BYTE_DOT;
						mirror_store[mirror_word_end+2] = BYTE_DOT;
						mirror_store[mirror_word_end+3] = BYTE_DOT;
						mirror_len = mirror_word_end + 4;
					end
					mirror_closed = 1'b1;
				end
			end
		end else if (m == MODE_READ && idx < mirror_len) begin
			res.data_byte = mirror_store[idx];
		end
		res.sample_length = mirror_len[OUT_LEN_W-1:0];
		res.truncated = mirror_closed;
		return res;
	endfunction

	// CSV-flavored text: letters, blanks, commas, quotes and multibyte points
	function automatic logic [CP_W-1:0] pick_code_point(bit wide);
		int r;

		if (wide && $urandom_range(0, 3) != 0) return CP_W'($urandom_range(21'h10000, 21'h10FFFF));
		r = $urandom_range(0, 99);
		if (r < 33) return CP_W'($urandom_range(21'h21, 21'h7E));
		if (r < 45) return CH_SPACE;
		if (r < 50) return CP_W'($urandom_range(0, 21'h1F));
		if (r < 53) return CH_NBSP;
		if (r < 61) return CH_COMMA;
		if (r < 73) return CH_QUOTE;
		if (r < 80) return CP_W'($urandom_range(21'h80, 21'h7FF));
		if (r < 87) return CP_W'($urandom_range(21'h800, 21'hFFFF));
		if (r < 94) return CP_W'($urandom_range(21'h10000, 21'h10FFFF));
		return CP_W'($urandom_range(0, 21'h1FFFFF));
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// offer one item; valid stays high into the next item when no gap follows
	task automatic send_item(input mode_t m, input logic [CP_W-1:0] cp,
			input logic [IDX_W-1:0] idx, input bit typed, input sample_result_t typed_res);
		sample_result_t res;
		int             gap;

		gap = sender_tight ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W-CP_W-IDX_W){1'b0}}, idx, cp};
		s_axis_tuser  <= m;
		do @(posedge clk); while (!s_axis_tready);
		res = sample_step(m, cp, idx);
		results_due.push_back(typed ? typed_res : res);
	endtask

	// register write once the block has drained
	task automatic write_limit(input logic [LIM_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_reg = value;
	endtask

	// result checker
	always @(posedge clk) begin
		sample_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (results_due.size() == 0) begin
				$display("%0t: beat expected none actual 0x%0h", $time, m_axis_tdata);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
				check_field("sample_length", want.sample_length, m_axis_tdata[17:8]);
				check_field("truncated", want.truncated, m_axis_tdata[18]);
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("csv_text_sample_builder_core verification failed");
			$finish;
		end
	end

	// receiver: random stalls, bursts without stalls, one long hold-off
	initial begin
		int hold;
		bit recv_tight;
		bit held;

		recv_tight = 1'b0;
		held = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0) recv_tight = ~recv_tight;
			hold = recv_tight ? 0 : $urandom_range(0, 15);
			if (!held && results_seen >= 120) begin
				held = 1'b1;
				hold = HOLD_OFF;
			end
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// stimulus
	initial begin
		script_row_t    row;
		sample_result_t typed_res;
		logic [LIM_W-1:0] lim;
		mode_t          m;
		logic [IDX_W-1:0] idx;
		bit             wide;
		int             counted;
		int             target;
		int             r;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (script_rows[i]) begin
			row = script_rows[i];
			if (row.kind == ROW_LIMIT) begin
				write_limit(row.idx);
			end else begin
				typed_res.data_byte = row.data_v;
				typed_res.sample_length = row.len_v;
				typed_res.truncated = row.trunc_v;
				send_item(row.mode, row.cp, row.idx, row.typed, typed_res);
			end
		end

		// random phases, each under its own limit; the first runs long wide text
		for (int phase = 0; phase < 10; phase++) begin
			wide = (phase == 0);
			if (wide) begin
				lim = 10'h3FF;
			end else begin
				case ($urandom_range(0, 5))
					0: lim = LIM_W'($urandom_range(0, 3));
					1: lim = LIM_W'(LIMIT_MIN);
					2: lim = LIM_W'($urandom_range(5, 24));
					3: lim = LIM_W'($urandom_range(25, 80));
					4: lim = LIMIT_RESET;
					default: lim = LIM_W'($urandom_range(0, 1023));
				endcase
			end
			write_limit(lim);
			sender_tight = ($urandom_range(0, 3) == 0);
			send_item(MODE_START, CP_W'($urandom_range(0, 21'h1FFFFF)),
				IDX_W'($urandom_range(0, 1023)), 1'b0, '0);
			counted = 1;
			target = wide ? 170 : 36;
			while (counted < target) begin
				r = $urandom_range(0, 99);
				if (mirror_closed && r < 40) m = MODE_START;
				else if (r < 78) m = MODE_PUSH;
				else if (r < 93) m = MODE_READ;
				else if (r < 96) m = MODE_NOP;
				else m = MODE_START;
				if (mirror_len > 0 && $urandom_range(0, 4) != 0)
					idx = IDX_W'($urandom_range(0, mirror_len - 1));
				else
					idx = IDX_W'($urandom_range(0, 1023));
				if (!(m == MODE_PUSH && mirror_closed)) counted++;
				send_item(m, (m == MODE_PUSH) ? pick_code_point(wide)
					: CP_W'($urandom_range(0, 21'h1FFFFF)), idx, 1'b0, '0);
			end
		end

		// drain
		s_axis_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("csv_text_sample_builder_core verification clean");
		else
			$display("csv_text_sample_builder_core verification failed");
		$finish;
	end

endmodule
